FILE: hw/rtl/tpaf_pkg.sv
`default_nettype none

package tpaf_pkg;

    // Sample width and the fixed-point scale that maps a level to a delay load
    localparam int ADC_BITS   = 10;
    localparam int LOAD_SCALE = 260;
    localparam int LOAD_ROUND = (1 << (ADC_BITS - 1)) - 1;
    localparam int PROD_W     = ADC_BITS + 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    // Commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ZCROSS = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSTSCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN = 3'd4;

    typedef enum logic [1:0] {
        MODE_PHASE = 2'd0,
        MODE_OFF   = 2'd1,
        MODE_ON    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [ADC_BITS-1:0] adc_value;
    } in_word_t;

    typedef struct packed {
        logic       gate;
        logic [1:0] mode;
        logic [7:0] delay_load;
    } out_word_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] low_cut;
        logic [ADC_BITS-1:0] high_cut;
        logic [4:0]          prescale_div;
        logic [4:0]          postscale_div;
        logic [7:0]          pulse_len;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] load;
    } sample_t;

    // Zero acts as one, anything above 16 as 16
    function automatic logic [4:0] clamp_div(input logic [4:0] d);
        logic [4:0] r;
        if (d == 5'd0) begin
            r = 5'd1;
        end else if (d > 5'd16) begin
            r = 5'd16;
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tpaf_sample_decode.sv
`default_nettype none

module tpaf_sample_decode (
    input  wire logic [tpaf_pkg::ADC_BITS-1:0] adc_value,
    input  wire tpaf_pkg::cfg_t                cfg,
    output tpaf_pkg::sample_t                  sample
);
    import tpaf_pkg::*;

    logic [PROD_W-1:0]          prod;
    logic [PROD_W-ADC_BITS-1:0] load_wide;

    // Scale the level to a delay load, rounding just below half
    assign prod      = PROD_W'(adc_value) * PROD_W'(LOAD_SCALE) + PROD_W'(LOAD_ROUND);
    assign load_wide = prod[PROD_W-1:ADC_BITS];

    always_comb begin
        if (adc_value <= cfg.low_cut) begin
            sample.mode = MODE_OFF;
        end else if (adc_value >= cfg.high_cut) begin
            sample.mode = MODE_ON;
        end else begin
            sample.mode = MODE_PHASE;
        end
        sample.load = (load_wide > (PROD_W-ADC_BITS)'(255)) ? 8'hFF : load_wide[7:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tpaf_phase_timer.sv
`default_nettype none

module tpaf_phase_timer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic [1:0]          command,
    input  wire tpaf_pkg::sample_t   sample,
    input  wire tpaf_pkg::cfg_t      cfg,
    output tpaf_pkg::out_word_t      result
);
    import tpaf_pkg::*;

    mode_t      mode_reg,      mode_next;
    logic [7:0] load_reg,      load_next;
    logic       running_reg,   running_next;
    logic [3:0] pre_cnt_reg,   pre_cnt_next;
    logic [7:0] per_cnt_reg,   per_cnt_next;
    logic [3:0] post_cnt_reg,  post_cnt_next;
    logic [7:0] pulse_cnt_reg, pulse_cnt_next;
    logic       gate_reg,      gate_next;

    logic [4:0] pre_inc;
    logic [4:0] post_inc;

    assign pre_inc  = {1'b0, pre_cnt_reg} + 5'd1;
    assign post_inc = {1'b0, post_cnt_reg} + 5'd1;

    always_comb begin
        mode_next      = mode_reg;
        load_next      = load_reg;
        running_next   = running_reg;
        pre_cnt_next   = pre_cnt_reg;
        per_cnt_next   = per_cnt_reg;
        post_cnt_next  = post_cnt_reg;
        pulse_cnt_next = pulse_cnt_reg;
        gate_next      = gate_reg;

        case (command)
            CMD_TICK: begin
                if (mode_reg == MODE_PHASE) begin
                    if (pulse_cnt_reg != 8'd0) begin
                        pulse_cnt_next = pulse_cnt_reg - 8'd1;
                        if (pulse_cnt_reg == 8'd1) begin
                            gate_next = 1'b0;
                        end
                    end
                    if (running_reg) begin
                        if (pre_inc < clamp_div(cfg.prescale_div)) begin
                            pre_cnt_next = pre_inc[3:0];
                        end else begin
                            pre_cnt_next = 4'd0;
                            if (per_cnt_reg < load_reg) begin
                                per_cnt_next = per_cnt_reg + 8'd1;
                            end else begin
                                per_cnt_next = 8'd0;
                                if (post_inc < clamp_div(cfg.postscale_div)) begin
                                    post_cnt_next = post_inc[3:0];
                                end else begin
                                    // fire: start the gate pulse
                                    post_cnt_next  = 4'd0;
                                    running_next   = 1'b0;
                                    gate_next      = 1'b1;
                                    pulse_cnt_next = (cfg.pulse_len == 8'd0) ? 8'd1
                                                                             : cfg.pulse_len;
                                end
                            end
                        end
                    end
                end
            end
            CMD_ZCROSS: begin
                if (mode_reg == MODE_PHASE) begin
                    running_next   = 1'b1;
                    pre_cnt_next   = 4'd0;
                    per_cnt_next   = 8'd0;
                    post_cnt_next  = 4'd0;
                    pulse_cnt_next = 8'd0;
                    gate_next      = 1'b0;
                end
            end
            CMD_SAMPLE: begin
                if (sample.mode != mode_reg) begin
                    running_next   = 1'b0;
                    pre_cnt_next   = 4'd0;
                    per_cnt_next   = 8'd0;
                    post_cnt_next  = 4'd0;
                    pulse_cnt_next = 8'd0;
                end
                mode_next = sample.mode;
                case (sample.mode)
                    MODE_OFF:   gate_next = 1'b0;
                    MODE_ON:    gate_next = 1'b1;
                    default:    load_next = sample.load;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PHASE;
            load_reg      <= 8'd0;
            running_reg   <= 1'b0;
            pre_cnt_reg   <= 4'd0;
            per_cnt_reg   <= 8'd0;
            post_cnt_reg  <= 4'd0;
            pulse_cnt_reg <= 8'd0;
            gate_reg      <= 1'b0;
        end else if (en) begin
            mode_reg      <= mode_next;
            load_reg      <= load_next;
            running_reg   <= running_next;
            pre_cnt_reg   <= pre_cnt_next;
            per_cnt_reg   <= per_cnt_next;
            post_cnt_reg  <= post_cnt_next;
            pulse_cnt_reg <= pulse_cnt_next;
            gate_reg      <= gate_next;
        end
    end

    assign result.gate       = gate_next;
    assign result.mode       = mode_next;
    assign result.delay_load = load_next;

    // A delay and a gate pulse never run together
    a_delay_pulse_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (pulse_cnt_reg == 8'd0))
        else $error("delay running while gate pulse active");

    // Held modes carry no timing
    a_held_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_PHASE) |-> (!running_reg && pulse_cnt_reg == 8'd0))
        else $error("timing active in a held mode");

    a_off_gate_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OFF) |-> !gate_reg)
        else $error("gate high while held off");

    a_on_gate_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_ON) |-> gate_reg)
        else $error("gate low while held on");

endmodule

`default_nettype wire

FILE: hw/rtl/triac_phase_angle_firing.sv
`default_nettype none

// A result word is registered and appears on m_data in the cycle after its input word is accepted.
// One word per cycle while the output slot is empty or drains; the state update and output
// register both load on the accepting edge, so back-to-back ticks keep phase timing exact.
// Reset (aresetn low, synchronous): phase mode, zero load, timers idle, gate low,
// no result pending, configuration registers back to their default values.
module triac_phase_angle_firing (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input word channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire tpaf_pkg::in_word_t                s_data,
    // result word channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output tpaf_pkg::out_word_t                    m_data,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [tpaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tpaf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tpaf_pkg::*;

    cfg_t      cfg_reg;
    sample_t   sample;
    out_word_t result;
    out_word_t m_data_reg;
    logic      m_valid_reg;
    logic      s_accept;

    // Take a new word whenever the output slot is empty or drains this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Configuration registers; writes to unknown indexes drop silently
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_cut       <= ADC_BITS'(51);
            cfg_reg.high_cut      <= ADC_BITS'(973);
            cfg_reg.prescale_div  <= 5'd4;
            cfg_reg.postscale_div <= 5'd8;
            cfg_reg.pulse_len     <= 8'd20;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOW_CUT:   cfg_reg.low_cut       <= cfg_data[ADC_BITS-1:0];
                REG_HIGH_CUT:  cfg_reg.high_cut      <= cfg_data[ADC_BITS-1:0];
                REG_PRESCALE:  cfg_reg.prescale_div  <= cfg_data[4:0];
                REG_POSTSCALE: cfg_reg.postscale_div <= cfg_data[4:0];
                REG_PULSE_LEN: cfg_reg.pulse_len     <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Classify the sample level and compute its delay load
    tpaf_sample_decode u_decode (
        .adc_value (s_data.adc_value),
        .cfg       (cfg_reg),
        .sample    (sample)
    );

    // Mode, delay and pulse timing; advance only on an accepted word
    tpaf_phase_timer u_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (s_accept),
        .command (s_data.command),
        .sample  (sample),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register: hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
